// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define AST_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ukvt_pkg.sv =====
// Package for the unsorted key/value table: action and status codes, the pair type.
// Depends on nothing; used by the top level and its checker.
package ukvt_pkg;

    localparam int CAPACITY_DEFAULT = 128;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_SEARCH = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_PRED   = 3'd3;
    localparam logic [2:0] ACT_SUCC   = 3'd4;
    localparam logic [2:0] ACT_MIN    = 3'd5;
    localparam logic [2:0] ACT_MAX    = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] value;
    } pair_t;

    // Signed less-than on two keys.
    function automatic logic key_less(logic signed [31:0] a, logic signed [31:0] b);
        return a < b;
    endfunction

endpackage

// ===== hw/rtl/unsorted_key_value_table.sv =====
// Unsorted key/value table: slots are kept in one RAM (a delete moves the last slot into
// the hole, so insertion order is not kept), and a small sequencer walks them through a
// single compare stage, one slot read per cycle. Insert and unused action codes need no
// scan; search and delete scan the slots up to the first match, and delete then moves
// the last slot into the freed one; minimum and maximum scan every slot; predecessor and
// successor run the find scan and, on a match, a full scan. in_stall stays high from
// acceptance until the result is loaded into the output register, which can hold a
// result while the next beat is taken. There is no clearing pass: slots are only read
// below the entry count.
module unsorted_key_value_table #(
    parameter int CAPACITY = ukvt_pkg::CAPACITY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] key,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] result_key,
    output logic signed [31:0] result_value,
    output logic [7:0]         entries_held
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIND   = 3'd1;
    localparam logic [2:0] S_BEST   = 3'd2;
    localparam logic [2:0] S_DEL_RD = 3'd3;
    localparam logic [2:0] S_DEL_WR = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2:0]         act_reg, act_next;
    logic signed [31:0] target_reg, target_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [CW-1:0]      chk_reg, chk_next;
    logic               rv_reg, rv_next;
    logic               have_reg, have_next;
    ukvt_pkg::pair_t    best_reg, best_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [1:0]         res_status_reg, res_status_next;
    ukvt_pkg::pair_t    res_pair_reg, res_pair_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    ukvt_pkg::pair_t    out_pair_reg, out_pair_next;
    logic [7:0]         out_held_reg, out_held_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    ukvt_pkg::pair_t    ram_wdata;
    logic [AW-1:0]      ram_raddr;
    ukvt_pkg::pair_t    ram_rdata;

    logic               accept;
    logic               last_chk;
    logic               want_small;
    logic               ext_mode;
    logic               side_ok;
    logic               better;
    logic               upd;
    logic               nhave;
    ukvt_pkg::pair_t    nbest;
    logic [CW-1:0]      last_idx;
    logic [31:0]        cnt_wide;
    ukvt_pkg::pair_t    zero_pair;
    ukvt_pkg::pair_t    in_pair;

    ukvt_ram #(
        .WIDTH ($bits(ukvt_pkg::pair_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign zero_pair = '0;
    assign in_pair   = '{key: key, value: value};
    assign last_idx  = cnt_reg - CW'(1);
    assign last_chk  = ((CW + 1)'(chk_reg) + (CW + 1)'(1)) == (CW + 1)'(cnt_reg);
    assign cnt_wide  = 32'(cnt_reg);

    // Compare stage shared by the neighbour and extreme scans.
    assign ext_mode   = (act_reg == ukvt_pkg::ACT_MIN) || (act_reg == ukvt_pkg::ACT_MAX);
    assign want_small = (act_reg == ukvt_pkg::ACT_SUCC) || (act_reg == ukvt_pkg::ACT_MIN);
    always_comb
    begin
        if (ext_mode)
        begin
            side_ok = 1'b1;
        end
        else if (act_reg == ukvt_pkg::ACT_SUCC)
        begin
            side_ok = ukvt_pkg::key_less(target_reg, ram_rdata.key);
        end
        else
        begin
            side_ok = ukvt_pkg::key_less(ram_rdata.key, target_reg);
        end
        if (want_small)
        begin
            better = ukvt_pkg::key_less(ram_rdata.key, best_reg.key);
        end
        else
        begin
            better = ukvt_pkg::key_less(best_reg.key, ram_rdata.key);
        end
    end
    assign upd   = rv_reg && side_ok && (!have_reg || better);
    assign nhave = have_reg || upd;
    assign nbest = upd ? ram_rdata : best_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        act_next        = act_reg;
        target_next     = target_reg;
        iss_next        = iss_reg;
        chk_next        = chk_reg;
        rv_next         = 1'b0;
        have_next       = have_reg;
        best_next       = best_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_pair_next   = res_pair_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pair_next   = out_pair_reg;
        out_held_next   = out_held_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg[AW-1:0];
        ram_wdata       = in_pair;
        ram_raddr       = iss_reg[AW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Slot reads issue one per cycle while a scan runs; data is checked in the next cycle.
        if ((state_reg == S_FIND) || (state_reg == S_BEST))
        begin
            if (iss_reg < cnt_reg)
            begin
                iss_next = iss_reg + CW'(1);
                chk_next = iss_reg;
                rv_next  = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = action;
                    target_next     = key;
                    iss_next        = '0;
                    have_next       = 1'b0;
                    res_status_next = ukvt_pkg::ST_OK;
                    res_pair_next   = zero_pair;
                    state_next      = S_FIN;
                    case (action)
                        ukvt_pkg::ACT_INSERT:
                        begin
                            if (32'(cnt_reg) < 32'(CAPACITY))
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            else
                            begin
                                res_status_next = ukvt_pkg::ST_FULL;
                            end
                        end
                        ukvt_pkg::ACT_SEARCH, ukvt_pkg::ACT_DELETE,
                        ukvt_pkg::ACT_PRED, ukvt_pkg::ACT_SUCC:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ukvt_pkg::ST_MISSING;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        ukvt_pkg::ACT_MIN, ukvt_pkg::ACT_MAX:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ukvt_pkg::ST_NONE;
                            end
                            else
                            begin
                                state_next = S_BEST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                if (rv_reg && (ram_rdata.key == target_reg))
                begin
                    slot_next = chk_reg[AW-1:0];
                    rv_next   = 1'b0;
                    if ((act_reg == ukvt_pkg::ACT_PRED) || (act_reg == ukvt_pkg::ACT_SUCC))
                    begin
                        iss_next   = '0;
                        have_next  = 1'b0;
                        state_next = S_BEST;
                    end
                    else
                    begin
                        res_pair_next = ram_rdata;
                        if (act_reg == ukvt_pkg::ACT_DELETE)
                        begin
                            state_next = S_DEL_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
                else if (rv_reg && last_chk)
                begin
                    res_status_next = ukvt_pkg::ST_MISSING;
                    state_next      = S_FIN;
                end
            end
            S_BEST:
            begin
                have_next = nhave;
                best_next = nbest;
                if (rv_reg && last_chk)
                begin
                    rv_next = 1'b0;
                    if (nhave)
                    begin
                        res_pair_next = nbest;
                    end
                    else
                    begin
                        res_status_next = ukvt_pkg::ST_NONE;
                    end
                    state_next = S_FIN;
                end
            end
            S_DEL_RD:
            begin
                ram_raddr  = last_idx[AW-1:0];
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                // The last slot moves into the hole; harmless when they are the same slot.
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = ram_rdata;
                cnt_next   = last_idx;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pair_next   = res_pair_reg;
                    out_held_next   = (cnt_wide > 32'd255) ? 8'hFF : cnt_wide[7:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        target_reg     <= target_next;
        iss_reg        <= iss_next;
        chk_reg        <= chk_next;
        have_reg       <= have_next;
        best_reg       <= best_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_pair_reg   <= res_pair_next;
        out_status_reg <= out_status_next;
        out_pair_reg   <= out_pair_next;
        out_held_reg   <= out_held_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_key   = out_pair_reg.key;
    assign result_value = out_pair_reg.value;
    assign entries_held = out_held_reg;

endmodule

// ===== hw/rtl/ukvt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the key/value slots of the table.
module ukvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/ukvt_checker.sv =====
// Port-level checker for the unsorted key/value table, bound to the top level.
// Depends on ukvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ukvt_checker #(
    parameter int CAPACITY = ukvt_pkg::CAPACITY_DEFAULT
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [31:0] result_key,
    input logic signed [31:0] result_value,
    input logic [7:0]         entries_held
);

    localparam logic [7:0] HELD_MAX = (CAPACITY > 255) ? 8'hFF : 8'(CAPACITY);

    logic        in_beat;
    logic        no_pair;
    logic        out_held_off;
    logic        full_beat;
    logic        pair_zero;
    logic [73:0] out_word;

    assign in_beat      = in_valid && !in_stall;
    assign no_pair      = (status == ukvt_pkg::ST_MISSING) || (status == ukvt_pkg::ST_FULL)
                          || (status == ukvt_pkg::ST_NONE);
    assign out_held_off = out_valid && out_stall;
    assign full_beat    = out_valid && (status == ukvt_pkg::ST_FULL);
    assign pair_zero    = (result_key == 32'sd0) && (result_value == 32'sd0);
    assign out_word     = {status, result_key, result_value, entries_held};

    // A result beat that is held off keeps its payload.
    `AST_NEXT(a_out_hold, out_held_off, out_valid && $stable(out_word), "stalled result changed")
    // Every accepted beat keeps the block busy on the next cycle.
    `AST_NEXT(a_busy_after_beat, in_beat, in_stall, "input taken again right after a beat")
    `AST_IMPLY(a_held_range, out_valid, entries_held <= HELD_MAX, "entry count above capacity")
    `AST_IMPLY(a_full_count, full_beat, entries_held == HELD_MAX, "full reported below capacity")
    `AST_IMPLY(a_no_pair_zero, out_valid && no_pair, pair_zero, "pair given with a failure status")

endmodule

bind unsorted_key_value_table ukvt_checker #(.CAPACITY(CAPACITY)) u_ukvt_checker (.*);

// ===== dv/unsorted_key_value_table_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for unsorted_key_value_table: a directed table, then random beats.
// Every result is compared with a directed expectation or a shadow copy of the table kept in the bench.
// Depends on ukvt_pkg and the unsorted_key_value_table RTL.
module unsorted_key_value_table_tb;

    localparam int CAPACITY = ukvt_pkg::CAPACITY_DEFAULT;
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] rkey;
        logic signed [31:0] rvalue;
        logic [7:0]         held;
    } table_result_t;

    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] k;
        logic signed [31:0] v;
        bit                 typed;
        table_result_t      want;
    } directed_row_t;

    typedef enum int {MIX_GENERAL, MIX_LOOKUP} action_mix_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] result_key;
    logic signed [31:0] result_value;
    logic [7:0]         entries_held;

    logic signed [31:0] shadow_keys [CAPACITY];
    logic signed [31:0] shadow_vals [CAPACITY];
    int                 shadow_count;

    table_result_t pending_results [$];
    directed_row_t directed_rows [$];

    bit steady_flow;
    int hold_request;
    int errors;
    int beats_sent;
    int results_checked;
    int full_rejects;
    int peak_count;
    int idle_cycles;

    unsorted_key_value_table #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .key(key),
        .value(value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .result_key(result_key),
        .result_value(result_value),
        .entries_held(entries_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int first_slot(logic signed [31:0] k);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_keys[i] == k)
                return i;
        end
        return shadow_count;
    endfunction

    // Applies one action to the shadow table and returns the result it should produce.
    function automatic table_result_t apply_action(logic [2:0] act, logic signed [31:0] k,
                                                   logic signed [31:0] v);
        table_result_t      r;
        int                 s;
        int                 pick;
        logic signed [31:0] c;
        bit                 side;
        bit                 want_succ;
        r = '0;
        r.status = ukvt_pkg::ST_OK;
        case (act)
            ukvt_pkg::ACT_INSERT:
            begin
                if (shadow_count < CAPACITY)
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_vals[shadow_count] = v;
                    shadow_count++;
                end
                else
                    r.status = ukvt_pkg::ST_FULL;
            end
            ukvt_pkg::ACT_SEARCH, ukvt_pkg::ACT_DELETE:
            begin
                s = first_slot(k);
                if (s < shadow_count)
                begin
                    r.rkey = shadow_keys[s];
                    r.rvalue = shadow_vals[s];
                    if (act == ukvt_pkg::ACT_DELETE)
                    begin
                        // The last entry moves into the freed slot.
                        shadow_keys[s] = shadow_keys[shadow_count - 1];
                        shadow_vals[s] = shadow_vals[shadow_count - 1];
                        shadow_count--;
                    end
                end
                else
                    r.status = ukvt_pkg::ST_MISSING;
            end
            ukvt_pkg::ACT_PRED, ukvt_pkg::ACT_SUCC:
            begin
                s = first_slot(k);
                if (s >= shadow_count)
                    r.status = ukvt_pkg::ST_MISSING;
                else
                begin
                    want_succ = (act == ukvt_pkg::ACT_SUCC);
                    pick = -1;
                    // Strict compares keep the lowest slot among equal neighbours.
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        c = shadow_keys[i];
                        side = want_succ ? (k < c) : (c < k);
                        if (side && (pick < 0 || (want_succ ? (c < shadow_keys[pick])
                                                            : (shadow_keys[pick] < c))))
                            pick = i;
                    end
                    if (pick < 0)
                        r.status = ukvt_pkg::ST_NONE;
                    else
                    begin
                        r.rkey = shadow_keys[pick];
                        r.rvalue = shadow_vals[pick];
                    end
                end
            end
            ukvt_pkg::ACT_MIN, ukvt_pkg::ACT_MAX:
            begin
                if (shadow_count == 0)
                    r.status = ukvt_pkg::ST_NONE;
                else
                begin
                    pick = 0;
                    for (int i = 1; i < shadow_count; i++)
                    begin
                        if ((act == ukvt_pkg::ACT_MAX) ? (shadow_keys[pick] < shadow_keys[i])
                                                       : (shadow_keys[i] < shadow_keys[pick]))
                            pick = i;
                    end
                    r.rkey = shadow_keys[pick];
                    r.rvalue = shadow_vals[pick];
                end
            end
            default:
            begin
            end
        endcase
        r.held = (shadow_count > 255) ? 8'd255 : 8'(shadow_count);
        return r;
    endfunction

    function automatic void add_row(logic [2:0] act, logic signed [31:0] k,
                                    logic signed [31:0] v, bit typed, logic [1:0] st,
                                    logic signed [31:0] rk, logic signed [31:0] rv,
                                    logic [7:0] held);
        directed_row_t r;
        r.act = act;
        r.k = k;
        r.v = v;
        r.typed = typed;
        r.want.status = st;
        r.want.rkey = rk;
        r.want.rvalue = rv;
        r.want.held = held;
        directed_rows.push_back(r);
    endfunction

    // Most keys are stored ones or a small cluster, so lookups hit and neighbours exist.
    function automatic logic signed [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (r < 75)
            return 32'($urandom_range(0, 16)) - 32'sd8;
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0: return KEY_MIN;
                1: return KEY_MAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_action(action_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_GENERAL)
        begin
            if (r < 32) return ukvt_pkg::ACT_INSERT;
            if (r < 44) return ukvt_pkg::ACT_SEARCH;
            if (r < 66) return ukvt_pkg::ACT_DELETE;
            if (r < 75) return ukvt_pkg::ACT_PRED;
            if (r < 84) return ukvt_pkg::ACT_SUCC;
            if (r < 90) return ukvt_pkg::ACT_MIN;
            if (r < 96) return ukvt_pkg::ACT_MAX;
            return ACT_UNUSED;
        end
        if (r < 25) return ukvt_pkg::ACT_INSERT;
        if (r < 45) return ukvt_pkg::ACT_SEARCH;
        if (r < 55) return ukvt_pkg::ACT_DELETE;
        if (r < 68) return ukvt_pkg::ACT_PRED;
        if (r < 81) return ukvt_pkg::ACT_SUCC;
        if (r < 89) return ukvt_pkg::ACT_MIN;
        if (r < 97) return ukvt_pkg::ACT_MAX;
        return ACT_UNUSED;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Entered and left just after a falling edge; valid stays up with the old payload on
    // exit, so the caller either sends again at once or lowers it.
    task automatic send_beat(logic [2:0] act, logic signed [31:0] k, logic signed [31:0] v,
                             bit typed, table_result_t want);
        int            gap;
        table_result_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key <= k;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_action(act, k, v);
        pending_results.push_back(typed ? want : predicted);
        beats_sent++;
        if (act == ukvt_pkg::ACT_INSERT && predicted.status == ukvt_pkg::ST_FULL)
            full_rejects++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        @(negedge clk);
    endtask

    task automatic send_random(action_mix_t mix);
        send_beat(pick_action(mix), pick_key(), $urandom, 1'b0, '0);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: a random stall before each result, and a long hold-off on request.
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            wait_cycles = steady_flow ? 0 : $urandom_range(0, 3);
            if (wait_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: status %0d key %0h",
                             $time, status, result_key);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("result_key", want.rkey, result_key);
                    check_field("result_value", want.rvalue, result_value);
                    check_field("entries_held", 32'(want.held), 32'(entries_held));
                    results_checked++;
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ukvt_pkg::ACT_INSERT;
        key = '0;
        value = '0;
        shadow_count = 0;
        steady_flow = 1'b0;
        hold_request = 0;
        errors = 0;
        beats_sent = 0;
        results_checked = 0;
        full_rejects = 0;
        peak_count = 0;
        idle_cycles = 0;

        // Empty table, unused code, extremes, duplicates, missing keys and edge neighbours.
        add_row(ukvt_pkg::ACT_MIN, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_NONE, 0, 0, 0);
        add_row(ukvt_pkg::ACT_MAX, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_NONE, 0, 0, 0);
        add_row(ukvt_pkg::ACT_SEARCH, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 0);
        add_row(ukvt_pkg::ACT_DELETE, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 0);
        add_row(ukvt_pkg::ACT_PRED, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 0);
        add_row(ukvt_pkg::ACT_SUCC, 32'sd5, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 0);
        add_row(ACT_UNUSED, -32'sd1, -32'sd1, 1, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_INSERT, KEY_MAX, KEY_MIN, 1, ukvt_pkg::ST_OK, 0, 0, 1);
        add_row(ukvt_pkg::ACT_INSERT, KEY_MIN, KEY_MAX, 1, ukvt_pkg::ST_OK, 0, 0, 2);
        add_row(ukvt_pkg::ACT_INSERT, 32'sd0, -32'sd1, 1, ukvt_pkg::ST_OK, 0, 0, 3);
        add_row(ukvt_pkg::ACT_INSERT, KEY_MAX, 32'sd1, 1, ukvt_pkg::ST_OK, 0, 0, 4);
        add_row(ukvt_pkg::ACT_MIN, 32'sd0, 32'sd0, 1, ukvt_pkg::ST_OK, KEY_MIN, KEY_MAX, 4);
        add_row(ukvt_pkg::ACT_MAX, 32'sd0, 32'sd0, 1, ukvt_pkg::ST_OK, KEY_MAX, KEY_MIN, 4);
        add_row(ukvt_pkg::ACT_SEARCH, KEY_MAX, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_PRED, KEY_MIN, 32'sd0, 1, ukvt_pkg::ST_NONE, 0, 0, 4);
        add_row(ukvt_pkg::ACT_SUCC, KEY_MAX, 32'sd0, 1, ukvt_pkg::ST_NONE, 0, 0, 4);
        add_row(ukvt_pkg::ACT_PRED, KEY_MAX, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_SUCC, KEY_MIN, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_SUCC, 32'sd1, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 4);
        add_row(ACT_UNUSED, KEY_MAX, KEY_MAX, 1, ukvt_pkg::ST_OK, 0, 0, 4);
        add_row(ukvt_pkg::ACT_DELETE, KEY_MIN, 32'sd0, 1, ukvt_pkg::ST_OK, KEY_MIN, KEY_MAX, 3);
        add_row(ukvt_pkg::ACT_SEARCH, KEY_MIN, 32'sd0, 1, ukvt_pkg::ST_MISSING, 0, 0, 3);
        add_row(ukvt_pkg::ACT_DELETE, KEY_MAX, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_SEARCH, KEY_MAX, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);
        add_row(ukvt_pkg::ACT_PRED, 32'sd0, 32'sd0, 0, ukvt_pkg::ST_OK, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].act, directed_rows[i].k, directed_rows[i].v,
                      directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < 600; n++)
            send_random(MIX_GENERAL);
        pause_until_drained();

        // Fill to capacity back to back, then keep inserting into the full table.
        steady_flow = 1'b1;
        while (shadow_count < CAPACITY)
            send_beat(ukvt_pkg::ACT_INSERT, pick_key(), $urandom, 1'b0, '0);
        steady_flow = 1'b0;
        repeat (8) send_beat(ukvt_pkg::ACT_INSERT, pick_key(), $urandom, 1'b0, '0);
        repeat (80) send_random(MIX_LOOKUP);

        // The receiver holds off while beats keep coming, so the input side backs up.
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) send_random(MIX_LOOKUP);
        pause_until_drained();

        while (shadow_count > 0)
            send_beat(ukvt_pkg::ACT_DELETE, ($urandom_range(0, 7) == 0) ? pick_key()
                      : shadow_keys[$urandom_range(0, shadow_count - 1)],
                      $urandom, 1'b0, '0);
        send_beat(ukvt_pkg::ACT_MIN, pick_key(), $urandom, 1'b0, '0);
        send_beat(ukvt_pkg::ACT_MAX, pick_key(), $urandom, 1'b0, '0);
        send_beat(ukvt_pkg::ACT_PRED, pick_key(), $urandom, 1'b0, '0);
        send_beat(ukvt_pkg::ACT_SUCC, pick_key(), $urandom, 1'b0, '0);
        send_beat(ukvt_pkg::ACT_DELETE, pick_key(), $urandom, 1'b0, '0);

        while (beats_sent < directed_rows.size() + RANDOM_ITEMS)
        begin
            if (beats_sent % 100 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_random(MIX_GENERAL);
        end
        steady_flow = 1'b0;

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d beats in, %0d results checked, %0d inserts refused as full",
                 beats_sent, results_checked, full_rejects);
        $display("summary: occupancy peaked at %0d of %0d slots, %0d mismatches",
                 peak_count, CAPACITY, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ukvt_pkg.sv
hw/rtl/ukvt_ram.sv
hw/rtl/unsorted_key_value_table.sv
hw/rtl/ukvt_checker.sv
dv/unsorted_key_value_table_tb.sv
